// ----- rtl/json_string_escape_decoder_defines.svh -----
// Assertion helpers for the decoder RTL.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef JSON_STRING_ESCAPE_DECODER_DEFINES_SVH
`define JSON_STRING_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication
`define JSED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define JSED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jsed_pkg.sv -----
package jsed_pkg;

  // Widths and sizes
  localparam int DEFAULT_POSITION_BITS = 16;
  localparam int POS_FIELD_W           = 16;
  localparam int VALUE_W               = 21;
  localparam int QUEUE_DEPTH           = 2;

  // Byte codes of interest
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;

  // Surrogate ranges and supplementary base
  localparam logic [15:0]        HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0]        HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0]        LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0]        LOW_SURR_HI  = 16'hDFFF;
  localparam logic [VALUE_W-1:0] SUPP_BASE    = 21'h10000;
  localparam logic [VALUE_W-1:0] CODE_MAX     = 21'h10FFFF;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ESCAPE  = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_CONTROL   = 2'd1,
    ERR_ESCAPE    = 2'd2,
    ERR_SURROGATE = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    PH_NORMAL         = 3'd0,
    PH_ESCAPE         = 3'd1,
    PH_HEX_FIRST      = 3'd2,
    PH_WANT_BACKSLASH = 3'd3,
    PH_WANT_U         = 3'd4,
    PH_HEX_SECOND     = 3'd5
  } phase_e;

  // One classified byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       is_quote;
    logic       is_backslash;
    logic       is_control;
    logic       is_u;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_simple;
    logic [6:0] simple_val;
  } entry_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] res;
    res = '0;
    unique case (c) inside
      [8'h30:8'h39]: res = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: res = {1'b1, c[3:0] + 4'd9};
      default:       res = '0;
    endcase
    return res;
  endfunction

  // {valid, decoded code point}
  function automatic logic [7:0] simple_decode(logic [7:0] c);
    logic [7:0] res;
    res = '0;
    unique case (c)
      CH_QUOTE:     res = {1'b1, CH_QUOTE[6:0]};
      CH_SLASH:     res = {1'b1, CH_SLASH[6:0]};
      CH_BACKSLASH: res = {1'b1, CH_BACKSLASH[6:0]};
      CH_B:         res = {1'b1, 7'h08};
      CH_F:         res = {1'b1, 7'h0C};
      CH_N:         res = {1'b1, 7'h0A};
      CH_R:         res = {1'b1, 7'h0D};
      CH_T:         res = {1'b1, 7'h09};
      default:      res = '0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/jsed_front.sv -----
module jsed_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output jsed_pkg::entry_t   q_entry_o
);
  import jsed_pkg::*;

  logic [4:0] hex_r;
  logic [7:0] simple_r;

  // Take a request whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the byte once, so the back end only selects
  assign hex_r    = hex_decode(data_byte_i);
  assign simple_r = simple_decode(data_byte_i);

  always_comb begin
    q_entry_o              = '0;
    q_entry_o.data         = data_byte_i;
    q_entry_o.is_quote     = (data_byte_i == CH_QUOTE);
    q_entry_o.is_backslash = (data_byte_i == CH_BACKSLASH);
    q_entry_o.is_control   = (data_byte_i < CTRL_LIMIT);
    q_entry_o.is_u         = (data_byte_i == CH_U);
    q_entry_o.is_hex       = hex_r[4];
    q_entry_o.hex_val      = hex_r[3:0];
    q_entry_o.is_simple    = simple_r[7];
    q_entry_o.simple_val   = simple_r[6:0];
  end

endmodule

// ----- rtl/jsed_fifo.sv -----
module jsed_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsed_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output jsed_pkg::entry_t pop_data_o
);
  import jsed_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FULL_CNT);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/jsed_back.sv -----
`include "json_string_escape_decoder_defines.svh"

module jsed_back #(
  parameter int POSITION_BITS = jsed_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  jsed_pkg::entry_t                q_entry_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [jsed_pkg::VALUE_W-1:0]    value_o,
  output logic [1:0]                      fault_code_o,
  output logic [jsed_pkg::POS_FIELD_W-1:0] position_o
);
  import jsed_pkg::*;

  localparam int PB = POSITION_BITS;

  // Decoder state
  phase_e          phase_q, phase_d;
  logic [15:0]     acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [9:0]      hs_q, hs_d;
  logic [PB-1:0]   off_q, off_d;
  logic [PB-1:0]   es_q, es_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  kind_e                  kind_q;
  logic [VALUE_W-1:0]     value_q;
  err_e                   err_q;
  logic [POS_FIELD_W-1:0] pos_q;

  // Step results
  logic               pop, emit, fail;
  kind_e              r_kind;
  logic [VALUE_W-1:0] r_val;
  err_e               r_err, fail_code;
  logic [PB-1:0]      r_pos, fail_pos;
  logic [POS_FIELD_W-1:0] r_pos16;
  logic [15:0]        acc_next;
  logic [PB-1:0]      off_inc, es6;
  logic [PB:0]        es6_sum;
  logic               acc_is_high, acc_is_low;

  // Work on the next queued byte when the output register is free or drains
  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  // Saturating offsets
  assign off_inc = (off_q == '1) ? off_q : off_q + 1'b1;
  assign es6_sum = {1'b0, es_q} + (PB+1)'(6);
  assign es6     = es6_sum[PB] ? '1 : es6_sum[PB-1:0];

  assign acc_next    = {acc_q[11:0], q_entry_i.hex_val};
  assign acc_is_high = (acc_next >= HIGH_SURR_LO) && (acc_next <= HIGH_SURR_HI);
  assign acc_is_low  = (acc_next >= LOW_SURR_LO) && (acc_next <= LOW_SURR_HI);

  // Phase machine: next state and result
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    hs_d      = hs_q;
    es_d      = es_q;
    off_d     = off_q;
    emit      = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    fail_pos  = off_q;
    r_kind    = KIND_LITERAL;
    r_val     = '0;
    r_err     = ERR_NONE;
    r_pos     = off_q;
    if (pop) begin
      off_d = off_inc;
      unique case (phase_q)
        PH_NORMAL: begin
          if (q_entry_i.is_backslash) begin
            es_d    = off_q;
            phase_d = PH_ESCAPE;
          end else if (q_entry_i.is_quote) begin
            emit   = 1'b1;
            r_kind = KIND_END;
            off_d  = '0;
          end else if (q_entry_i.is_control) begin
            fail      = 1'b1;
            fail_code = ERR_CONTROL;
            fail_pos  = off_q;
          end else begin
            emit  = 1'b1;
            r_val = {{(VALUE_W-8){1'b0}}, q_entry_i.data};
          end
        end
        PH_ESCAPE: begin
          if (q_entry_i.is_simple) begin
            emit    = 1'b1;
            r_kind  = KIND_ESCAPE;
            r_val   = {{(VALUE_W-7){1'b0}}, q_entry_i.simple_val};
            r_pos   = es_q;
            phase_d = PH_NORMAL;
          end else if (q_entry_i.is_u) begin
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PH_HEX_FIRST;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_ESCAPE;
            fail_pos  = es_q;
          end
        end
        PH_HEX_FIRST: begin
          if (!q_entry_i.is_hex) begin
            fail      = 1'b1;
            fail_code = ERR_ESCAPE;
            fail_pos  = es_q;
          end else begin
            acc_d = acc_next;
            cnt_d = cnt_q + 1'b1;
            // fourth digit completes the escape
            if (cnt_q == 2'd3) begin
              if (acc_is_high) begin
                hs_d    = acc_next[9:0];
                phase_d = PH_WANT_BACKSLASH;
              end else if (acc_is_low) begin
                fail      = 1'b1;
                fail_code = ERR_SURROGATE;
                fail_pos  = es_q;
              end else begin
                emit    = 1'b1;
                r_kind  = KIND_ESCAPE;
                r_val   = {{(VALUE_W-16){1'b0}}, acc_next};
                r_pos   = es_q;
                phase_d = PH_NORMAL;
              end
            end
          end
        end
        PH_WANT_BACKSLASH: begin
          if (q_entry_i.is_backslash) begin
            phase_d = PH_WANT_U;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_SURROGATE;
            fail_pos  = es_q;
          end
        end
        PH_WANT_U: begin
          if (q_entry_i.is_u) begin
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PH_HEX_SECOND;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_SURROGATE;
            fail_pos  = es_q;
          end
        end
        PH_HEX_SECOND: begin
          if (!q_entry_i.is_hex) begin
            fail      = 1'b1;
            fail_code = ERR_ESCAPE;
            fail_pos  = es6;
          end else begin
            acc_d = acc_next;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == 2'd3) begin
              if (!acc_is_low) begin
                fail      = 1'b1;
                fail_code = ERR_SURROGATE;
                fail_pos  = es6;
              end else begin
                // combine the pair into a supplementary code point
                emit    = 1'b1;
                r_kind  = KIND_ESCAPE;
                r_val   = {1'b0, hs_q, acc_next[9:0]} + SUPP_BASE;
                r_pos   = es_q;
                phase_d = PH_NORMAL;
              end
            end
          end
        end
        default: begin
          fail      = 1'b1;
          fail_code = ERR_ESCAPE;
          fail_pos  = off_q;
        end
      endcase
      // An error ends the string and clears the decoder
      if (fail) begin
        phase_d = PH_NORMAL;
        acc_d   = '0;
        cnt_d   = '0;
        hs_d    = '0;
        off_d   = '0;
        emit    = 1'b1;
        r_kind  = KIND_ERROR;
        r_val   = '0;
        r_err   = fail_code;
        r_pos   = fail_pos;
      end
    end
  end

  // Position field carries the low bits of the offset
  if (PB >= POS_FIELD_W) begin : g_pos_trunc
    assign r_pos16 = r_pos[POS_FIELD_W-1:0];
  end else begin : g_pos_ext
    assign r_pos16 = {{(POS_FIELD_W-PB){1'b0}}, r_pos};
  end

  assign out_valid_d = (pop && emit) || (out_valid_q && out_stall_i);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      acc_q       <= '0;
      cnt_q       <= '0;
      hs_q        <= '0;
      off_q       <= '0;
      es_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      hs_q        <= hs_d;
      off_q       <= off_d;
      es_q        <= es_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      kind_q  <= r_kind;
      value_q <= r_val;
      err_q   <= r_err;
      pos_q   <= r_pos16;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign fault_code_o = err_q;
  assign position_o   = pos_q;

  `JSED_ASSERT_IMPL(a_err_payload, out_valid_q && kind_q == KIND_ERROR, value_q == '0 && err_q != ERR_NONE, "error result with value or without code")
  `JSED_ASSERT_IMPL(a_ok_no_code, out_valid_q && kind_q != KIND_ERROR, err_q == ERR_NONE, "error code on a non-error result")
  `JSED_ASSERT_NEXT(a_offset_restart, pop && emit && (r_kind == KIND_END || r_kind == KIND_ERROR), off_q == '0 && phase_q == PH_NORMAL, "string end did not restart offset")
  `JSED_ASSERT_IMPL(a_code_range, out_valid_q, value_q <= CODE_MAX, "code point out of range")

endmodule

// ----- rtl/json_string_escape_decoder.sv -----
// JSON string escape decoder.
// Input channel: one byte of string body per request (data_byte_i), starting
// after the opening quote, on in_valid_i / in_stall_o.
// Output channel: one result per literal byte, completed escape, closing
// quote or error on out_valid_o / out_stall_i, with kind, value, fault code
// and position. Bytes inside an escape that do not complete it give no result.
// Throughput: one byte per cycle sustained unless the receiver stalls; the
// back-end phase machine handles one queued byte per cycle while not stalled.
// Path: an accepted byte is written into the queue, and its result is then
// registered in the output register from which the receiver takes it.
// A two-entry queue sits between the classifying front end and the phase
// machine; when the receiver stalls, the output register holds its result,
// the queue fills and in_stall_o rises once it is full.
// Reset: the queue and output register empty, decoding starts at offset 0
// of a new string in normal content. An error or closing quote also restarts
// the offset at 0.
module json_string_escape_decoder #(
  parameter int POSITION_BITS = jsed_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [jsed_pkg::VALUE_W-1:0]     value_o,
  output logic [1:0]                       fault_code_o,
  output logic [jsed_pkg::POS_FIELD_W-1:0] position_o
);
  import jsed_pkg::*;

  logic   q_full, q_push, q_valid, q_pop;
  entry_t q_wr_entry, q_rd_entry;

  jsed_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry)
  );

  jsed_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wr_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rd_entry)
  );

  jsed_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .fault_code_o (fault_code_o),
    .position_o   (position_o)
  );

endmodule
